### hdl/vfdg_pkg.sv
// shared types, constants and frame helpers for the vfd grid frame builder
`timescale 1ns / 1ps
`default_nettype none

package vfdg_pkg;

    // display geometry
    localparam int NUM_GRIDS    = 11;
    localparam int FRAME_WIDTH  = 16;
    localparam int DIGIT_COUNT  = 10;
    localparam int LANE_DIGITS  = DIGIT_COUNT / 2;

    // special grids
    localparam logic [3:0] SKIPPED_GRID = 4'd6;
    localparam logic [3:0] DP_GRID_A    = 4'd4;
    localparam logic [3:0] DP_GRID_B    = 4'd9;
    localparam logic [3:0] LAST_GRID    = 4'(NUM_GRIDS - 1);
    localparam logic [3:0] LAST_SLOT    = 4'(DIGIT_COUNT - 1);
    localparam logic [3:0] TOP_BIT      = 4'(FRAME_WIDTH - 1);
    localparam int         DP_BIT_POS   = 4;

    // voltage saturation limit
    localparam logic [14:0] VOLT_MAX = 15'd30000;

    // reciprocal of ten for 16-bit operands, quotient is product >> 19
    localparam logic [15:0] DIV10_MAGIC = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef logic [3:0]             digit_t;
    typedef logic [3:0]             slot_t;
    typedef logic [3:0]             grid_t;
    typedef logic [FRAME_WIDTH-1:0] frame_t;
    typedef logic [DIGIT_COUNT-1:0][3:0] digits_t;

    // front to queue write side
    typedef struct packed {
        logic    push;
        digits_t digits;
    } qwr_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic    avail;
        digits_t digits;
    } qrd_t;

    // slot to grid mapping, grid 6 is skipped
    function automatic grid_t grid_for(input slot_t slot);
        grid_t g;
        g = (slot < SKIPPED_GRID) ? slot : 4'(slot + 4'd1);
        return g;
    endfunction

    // inverted frame: digit, decimal point and one-hot grid select
    function automatic frame_t make_frame(input digit_t digit, input grid_t grid);
        frame_t v;
        v = {{(FRAME_WIDTH-4){1'b0}}, digit};
        if (grid == DP_GRID_A || grid == DP_GRID_B)
        begin
            v[DP_BIT_POS] = 1'b1;
        end
        if (grid <= LAST_GRID)
        begin
            v[TOP_BIT - grid] = 1'b1;
        end
        return ~v;
    endfunction

endpackage

`default_nettype wire

### hdl/vfdg_if.sv
// valid/ready channel interfaces for readings and grid frames
`timescale 1ns / 1ps
`default_nettype none

interface vfdg_in_if;
    logic        valid;
    logic        ready;
    logic [14:0] volt_mv;
    logic [15:0] amp_ma;

    modport source (output valid, output volt_mv, output amp_ma, input ready);
    modport sink   (input valid, input volt_mv, input amp_ma, output ready);
endinterface

interface vfdg_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_bits;
    logic [3:0]  grid_pos;
    logic        last_frame;

    modport source (output valid, output frame_bits, output grid_pos, output last_frame,
                    input ready);
    modport sink   (input valid, input frame_bits, input grid_pos, input last_frame,
                    output ready);
endinterface

`default_nettype wire

### hdl/vfdg_front.sv
// front end: accepts a reading and splits it into ten decimal digits
`timescale 1ns / 1ps
`default_nettype none

module vfdg_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    vfdg_in_if.sink            in_ch,
    input  wire logic          q_full,
    output vfdg_pkg::qwr_t     q_wr
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_PUSH} state_t;

    localparam int LW = 4 * vfdg_pkg::LANE_DIGITS;
    localparam logic [2:0] LAST_STEP = 3'(vfdg_pkg::LANE_DIGITS - 1);

    state_t      state_reg;
    logic [2:0]  step_reg;
    logic [15:0] lo_reg;
    logic [15:0] hi_reg;
    logic [LW-1:0] dlo_reg;
    logic [LW-1:0] dhi_reg;

    logic [14:0] volt_sat;
    logic [31:0] lo_prod;
    logic [31:0] hi_prod;
    logic [15:0] lo_q;
    logic [15:0] hi_q;
    logic [15:0] lo_rem;
    logic [15:0] hi_rem;
    logic        accept;
    logic        push;

    // voltage saturation
    assign volt_sat = (in_ch.volt_mv > vfdg_pkg::VOLT_MAX) ? vfdg_pkg::VOLT_MAX
                                                          : in_ch.volt_mv;

    // divide both lanes by ten, current lane holds the low five digits
    assign lo_prod = 32'(lo_reg) * 32'(vfdg_pkg::DIV10_MAGIC);
    assign hi_prod = 32'(hi_reg) * 32'(vfdg_pkg::DIV10_MAGIC);
    assign lo_q    = 16'(lo_prod >> vfdg_pkg::DIV10_SHIFT);
    assign hi_q    = 16'(hi_prod >> vfdg_pkg::DIV10_SHIFT);
    assign lo_rem  = lo_reg - 16'((lo_q << 3) + (lo_q << 1));
    assign hi_rem  = hi_reg - 16'((hi_q << 3) + (hi_q << 1));

    // handshake
    assign push         = (state_reg == ST_PUSH) && !q_full;
    assign in_ch.ready  = (state_reg == ST_IDLE) || push;
    assign accept       = in_ch.valid && in_ch.ready;
    assign q_wr.push    = push;
    assign q_wr.digits  = vfdg_pkg::digits_t'({dhi_reg, dlo_reg});

    // digit extraction sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= 3'd0;
                    end
                end
                ST_RUN:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_PUSH:
                begin
                    if (push)
                    begin
                        state_reg <= accept ? ST_RUN : ST_IDLE;
                        step_reg  <= 3'd0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // lane operands and digit shift registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= in_ch.amp_ma;
            hi_reg <= {1'b0, volt_sat};
        end
        else if (state_reg == ST_RUN)
        begin
            lo_reg  <= lo_q;
            hi_reg  <= hi_q;
            dlo_reg <= {lo_rem[3:0], dlo_reg[LW-1:4]};
            dhi_reg <= {hi_rem[3:0], dhi_reg[LW-1:4]};
        end
    end

endmodule

`default_nettype wire

### hdl/vfdg_queue.sv
// short queue of digit records between front and back ends
`timescale 1ns / 1ps
`default_nettype none

module vfdg_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vfdg_pkg::qwr_t q_wr,
    input  wire logic          pop,
    output logic               full,
    output vfdg_pkg::qrd_t     q_rd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    vfdg_pkg::digits_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full        = (count_reg == CW'(DEPTH));
    assign q_rd.avail  = (count_reg != '0);
    assign q_rd.digits = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem[wr_ptr_reg] <= q_wr.digits;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_wr.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            if (q_wr.push && !pop)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (pop && !q_wr.push)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

`ifndef ASSERT_OFF
    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_wr.push)
        else $error("push into full queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_rd.avail)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### hdl/vfdg_back.sv
// back end: turns one digit record into ten inverted grid frames
`timescale 1ns / 1ps
`default_nettype none

module vfdg_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vfdg_pkg::qrd_t q_rd,
    output logic               pop,
    vfdg_out_if.source         out_ch
);

    logic                  ov_reg;
    vfdg_pkg::slot_t       cnt_reg;
    vfdg_pkg::frame_t      frame_reg;
    vfdg_pkg::grid_t       grid_reg;
    logic                  last_reg;

    vfdg_pkg::grid_t       grid;
    vfdg_pkg::digit_t      digit;
    logic                  load;
    logic                  last_slot;

    // current slot of the queue head
    assign grid      = vfdg_pkg::grid_for(cnt_reg);
    assign digit     = q_rd.digits[cnt_reg];
    assign last_slot = (cnt_reg == vfdg_pkg::LAST_SLOT);
    assign load      = q_rd.avail && (!ov_reg || out_ch.ready);
    assign pop       = load && last_slot;

    assign out_ch.valid      = ov_reg;
    assign out_ch.frame_bits = frame_reg;
    assign out_ch.grid_pos   = grid_reg;
    assign out_ch.last_frame = last_reg;

    // frame counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                ov_reg  <= 1'b1;
                cnt_reg <= last_slot ? '0 : 4'(cnt_reg + 4'd1);
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= vfdg_pkg::make_frame(digit, grid);
            grid_reg  <= grid;
            last_reg  <= last_slot;
        end
    end

`ifndef ASSERT_OFF
    // the last frame of an update always goes to the top grid
    a_last_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (last_reg == (grid_reg == vfdg_pkg::LAST_GRID)))
        else $error("last flag and grid disagree");

    // the skipped grid never gets a frame and its select bit stays off
    a_skip_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (grid_reg != vfdg_pkg::SKIPPED_GRID
                    && frame_reg[vfdg_pkg::TOP_BIT - vfdg_pkg::SKIPPED_GRID]))
        else $error("frame for skipped grid");
`endif

endmodule

`default_nettype wire

### hdl/vfd_decimal_grid_frame_builder.sv
// top level of the vfd decimal grid frame builder
// path: a reading is split into digits, queued, then loaded into the frame output register
// throughput: ten frames per reading, set by the back end emitting one frame per cycle while
// the output is ready; the digit split runs on two divide-by-ten lanes
// the queue lets the next reading be split while the current frames drain
// reset: asynchronous active low, clears sequencer, queue pointers and frame counter
`timescale 1ns / 1ps
`default_nettype none

module vfd_decimal_grid_frame_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    vfdg_in_if.sink      in_ch,
    vfdg_out_if.source   out_ch
);

    vfdg_pkg::qwr_t q_wr;
    vfdg_pkg::qrd_t q_rd;
    logic           q_full;
    logic           q_pop;

    // reading intake and digit split
    vfdg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    // record queue
    vfdg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    // frame generation
    vfdg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
